// ===== design/bms_pkg.sv =====
package bms_pkg;

  // Note table size and address width
  localparam int MAX_NOTES = 64;
  localparam int NOTE_AW   = $clog2(MAX_NOTES);

  // Field widths
  localparam int FUNC_W  = 3;
  localparam int MS_W    = 32;
  localparam int LEN_W   = 7;
  localparam int IDX_W   = 6;
  localparam int FREQ_W  = 16;
  localparam int TYPE_W  = 15;
  localparam int SOUND_W = 10;
  localparam int SLOT_W  = 11;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 32;

  // Note length: 1000 / type, then slot = floor(d * 13 / 10)
  localparam logic [SOUND_W-1:0] WHOLE_MS   = SOUND_W'(1000);
  localparam int                 DIV_STEPS  = SOUND_W;
  localparam int                 CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int                 Q13_W      = 14;
  localparam int                 RECIP_W    = 16;
  localparam logic [RECIP_W-1:0] RECIP_10   = 16'd52429;   // 2^19 / 10, rounded up
  localparam int                 RECIP_SH   = 19;
  localparam int                 PROD_W     = Q13_W + RECIP_W;

  // Command codes carried on in_tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_BEEP   = 3'd1,
    FN_MELODY = 3'd2,
    FN_STOP   = 3'd3,
    FN_LOAD   = 3'd4
  } func_t;

  // Sequencer mode, also reported on the output word
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DELAY  = 2'd1,
    MODE_BEEP   = 2'd2,
    MODE_MELODY = 2'd3
  } mode_t;

  // Control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_MEL_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SLOT,
    ST_CMP,
    ST_OUT
  } state_t;

  // Divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/bms_div.sv =====
module bms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bms_pkg::TYPE_W-1:0]    divisor,
  output bms_pkg::div_stat_t            stat,
  output logic [bms_pkg::SOUND_W-1:0]   quotient
);
  import bms_pkg::*;

  logic [TYPE_W-1:0]  den_r,  den_nxt;
  logic [TYPE_W-1:0]  rem_r,  rem_nxt;
  logic [SOUND_W-1:0] quo_r,  quo_nxt;
  logic [CNT_W-1:0]   cnt_r,  cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TYPE_W:0]    trial;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[SOUND_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = WHOLE_MS;
      cnt_nxt  = CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? TYPE_W'(trial - {1'b0, den_r}) : trial[TYPE_W-1:0];
      quo_nxt = {quo_r[SOUND_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== design/beep_and_melody_sequencer.sv =====
// Flow: a tick or command passes the settle state (and in melody mode the note check)
// before its result word is offered; each melody note that starts runs the 10-step divider.
// One item at a time: a new item is taken the cycle after the result word leaves;
// the output state holds until out_tready, and a run of zero-length notes is walked
// within the one item.
// Reset (rst_n low, synchronous): idle mode, pin low, counters and positions zero.
// The note table is not cleared and holds unknown values until loaded.
module beep_and_melody_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: beep_ms[31:0], delay_ms[63:32], melody_length[70:64], note_index[76:71],
  //        note_freq[92:77], note_type[107:93], zero[111:108]
  input  logic [bms_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: func[2:0]
  input  logic [bms_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: mode[1:0], pin_high[2], tone_on[3], tone_freq[19:4],
  //        melody_position[26:20], zero[31:27]
  output logic [bms_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import bms_pkg::*;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [MS_W-1:0]     elapsed_r, elapsed_nxt;
  logic [MS_W-1:0]     beep_len_r, beep_len_nxt;
  logic [MS_W-1:0]     delay_len_r, delay_len_nxt;
  logic [LEN_W-1:0]    total_r, total_nxt;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SOUND_W-1:0]  sound_r, sound_nxt;
  logic                pin_r, pin_nxt;

  // Input word fields
  logic [MS_W-1:0]     f_beep_ms;
  logic [MS_W-1:0]     f_delay_ms;
  logic [LEN_W-1:0]    f_len;
  logic [IDX_W-1:0]    f_idx;
  logic [FREQ_W-1:0]   f_freq;
  logic [TYPE_W-1:0]   f_type;
  logic                in_fire;

  // Note table: {type, freq}
  logic [TYPE_W+FREQ_W-1:0] note_mem [MAX_NOTES];
  logic [TYPE_W+FREQ_W-1:0] rd_r;
  logic                     mem_we;
  logic [FREQ_W-1:0]        rd_freq;
  logic [TYPE_W-1:0]        rd_type;

  // Divider and slot arithmetic
  logic                div_start;
  logic [TYPE_W-1:0]   div_den;
  div_stat_t           div_stat;
  logic [SOUND_W-1:0]  div_q;
  logic [Q13_W-1:0]    q13;
  logic [PROD_W-1:0]   slot_prod;

  logic                mel_end;
  logic                tone_on;

  assign f_beep_ms  = in_tdata[31:0];
  assign f_delay_ms = in_tdata[63:32];
  assign f_len      = in_tdata[70:64];
  assign f_idx      = in_tdata[76:71];
  assign f_freq     = in_tdata[92:77];
  assign f_type     = in_tdata[107:93];
  assign in_fire    = in_tvalid && in_tready;

  assign rd_freq = rd_r[FREQ_W-1:0];
  assign rd_type = rd_r[TYPE_W+FREQ_W-1:FREQ_W];

  // Note table: one write port, one registered read at the current position
  assign mem_we = in_fire && (func_t'(in_tuser) == FN_LOAD) &&
                  ({1'b0, f_idx} < (IDX_W+1)'(MAX_NOTES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[f_idx[NOTE_AW-1:0]] <= {f_type, f_freq};
    end
    rd_r <= note_mem[pos_r[NOTE_AW-1:0]];
  end

  // Divisor of zero counts as one
  assign div_den = (rd_type == '0) ? TYPE_W'(1) : rd_type;

  bms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // slot = floor(d * 13 / 10) through a reciprocal multiply
  assign q13       = (Q13_W'(div_q) << 3) + (Q13_W'(div_q) << 2) + Q13_W'(div_q);
  assign slot_prod = PROD_W'(q13) * PROD_W'(RECIP_10);

  assign mel_end = (pos_r >= total_r) || (pos_r >= LEN_W'(MAX_NOTES));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_SETTLE;
      ST_SETTLE:   state_nxt = (mode_r == MODE_MELODY) ? ST_MEL_CHK : ST_OUT;
      ST_MEL_CHK: begin
        if (mel_end) begin
          state_nxt = ST_OUT;
        end else if (slot_r == '0) begin
          state_nxt = ST_DIV_GO;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_nxt = ST_SLOT;
      ST_SLOT:     state_nxt = ST_CMP;
      ST_CMP:      state_nxt = (elapsed_r >= MS_W'(slot_r)) ? ST_MEL_CHK : ST_OUT;
      ST_OUT:      if (out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    mode_t           m;
    logic [MS_W-1:0] e;
    logic            p;
    mode_nxt      = mode_r;
    elapsed_nxt   = elapsed_r;
    beep_len_nxt  = beep_len_r;
    delay_len_nxt = delay_len_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    slot_nxt      = slot_r;
    sound_nxt     = sound_r;
    pin_nxt       = pin_r;
    m             = mode_r;
    e             = elapsed_r;
    p             = pin_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (func_t'(in_tuser))
            FN_TICK: begin
              if (elapsed_r != '1) elapsed_nxt = elapsed_r + MS_W'(1);
            end
            FN_BEEP: begin
              beep_len_nxt  = f_beep_ms;
              delay_len_nxt = f_delay_ms;
              mode_nxt      = MODE_DELAY;
              elapsed_nxt   = '0;
            end
            FN_MELODY: begin
              total_nxt   = (f_len > LEN_W'(MAX_NOTES)) ? LEN_W'(MAX_NOTES) : f_len;
              pos_nxt     = '0;
              slot_nxt    = '0;
              elapsed_nxt = '0;
              pin_nxt     = 1'b0;
              mode_nxt    = MODE_MELODY;
            end
            FN_STOP: begin
              mode_nxt = MODE_IDLE;
              pin_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // Beep delay and beep end can both fall due in one item
      ST_SETTLE: begin
        if (m == MODE_DELAY && e >= delay_len_r) begin
          m = MODE_BEEP;
          e = '0;
          p = 1'b1;
        end
        if (m == MODE_BEEP && e >= beep_len_r) begin
          m = MODE_IDLE;
          p = 1'b0;
        end
        mode_nxt    = m;
        elapsed_nxt = e;
        pin_nxt     = p;
      end
      ST_MEL_CHK: begin
        if (mel_end) mode_nxt = MODE_IDLE;
      end
      // Note start: sound time and slot time from the divider
      ST_SLOT: begin
        sound_nxt   = div_q;
        slot_nxt    = slot_prod[RECIP_SH +: SLOT_W];
        elapsed_nxt = '0;
      end
      ST_CMP: begin
        if (elapsed_r >= MS_W'(slot_r)) begin
          slot_nxt = '0;
          pos_nxt  = pos_r + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_IDLE;
      elapsed_r   <= '0;
      beep_len_r  <= '0;
      delay_len_r <= '0;
      total_r     <= '0;
      pos_r       <= '0;
      slot_r      <= '0;
      sound_r     <= '0;
      pin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      elapsed_r   <= elapsed_nxt;
      beep_len_r  <= beep_len_nxt;
      delay_len_r <= delay_len_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      slot_r      <= slot_nxt;
      sound_r     <= sound_nxt;
      pin_r       <= pin_nxt;
    end
  end

  // Handshake and result word
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    div_start  = (state_r == ST_DIV_GO);
  end

  assign tone_on = (mode_r == MODE_MELODY) && (slot_r != '0) &&
                   (elapsed_r < MS_W'(sound_r)) && (pos_r < LEN_W'(MAX_NOTES));

  assign out_tdata = {5'b0, pos_r, (tone_on ? rd_freq : '0), tone_on, pin_r, mode_r};

endmodule

// ===== verif/bms_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the sequencer, predicts one result word per
// accepted input word and compares each accepted result word with the oldest
// prediction.
module bms_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bms_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [bms_pkg::FUNC_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bms_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              errors,
  output int                              pending,
  output int                              words_checked,
  output int                              notes_started,
  output int                              beeps_sounded
);
  import bms_pkg::*;

  // One predicted result word
  typedef struct packed {
    mode_t             mode;
    logic              pin;
    logic              tone;
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  pos;
  } tone_word_t;

  // Predicted sequencer state
  mode_t              run_mode;
  logic [MS_W-1:0]    ms_elapsed;
  logic [MS_W-1:0]    on_time;
  logic [MS_W-1:0]    wait_time;
  logic [FREQ_W-1:0]  tbl_freq [MAX_NOTES];
  logic [TYPE_W-1:0]  tbl_type [MAX_NOTES];
  logic [LEN_W-1:0]   tune_len;
  logic [LEN_W-1:0]   tune_pos;
  logic [SLOT_W-1:0]  note_slot;
  logic [SOUND_W-1:0] note_sound;
  logic               pin_level;

  tone_word_t expected_words [$];
  tone_word_t oldest;

  int err_count   = 0;
  int pend_count  = 0;
  int done_count  = 0;
  int note_count  = 0;
  int beep_count  = 0;

  assign errors        = err_count;
  assign pending       = pend_count;
  assign words_checked = done_count;
  assign notes_started = note_count;
  assign beeps_sounded = beep_count;

  // Reset state; the note table stays unknown until loaded
  task reset_sequencer();
    run_mode   = MODE_IDLE;
    ms_elapsed = '0;
    on_time    = '0;
    wait_time  = '0;
    tune_len   = '0;
    tune_pos   = '0;
    note_slot  = '0;
    note_sound = '0;
    pin_level  = 1'b0;
  endtask

  // Take all transitions due at the current elapsed time
  task settle_sequencer();
    int   kind;
    int   dur;
    logic walking;
    if (run_mode == MODE_DELAY && ms_elapsed >= wait_time) begin
      run_mode   = MODE_BEEP;
      ms_elapsed = '0;
      pin_level  = 1'b1;
      beep_count++;
    end
    if (run_mode == MODE_BEEP && ms_elapsed >= on_time) begin
      run_mode  = MODE_IDLE;
      pin_level = 1'b0;
    end
    walking = (run_mode == MODE_MELODY);
    while (walking) begin
      if (tune_pos >= tune_len || tune_pos >= MAX_NOTES) begin
        run_mode = MODE_IDLE;
        walking  = 1'b0;
      end else begin
        // start the note: tone 1000/type ms, slot 1.3 times that
        if (note_slot == '0) begin
          kind = int'(tbl_type[tune_pos[NOTE_AW-1:0]]);
          if (kind == 0) kind = 1;
          dur        = 1000 / kind;
          note_sound = SOUND_W'(dur);
          note_slot  = SLOT_W'((dur * 13) / 10);
          ms_elapsed = '0;
          note_count++;
        end
        if (ms_elapsed >= note_slot) begin
          note_slot = '0;
          tune_pos  = tune_pos + 1'b1;
        end else begin
          walking = 1'b0;
        end
      end
    end
  endtask

  // Apply one input word and form the result word it causes
  task apply_word(input logic [FUNC_W-1:0] fn, input logic [IN_TDATA_W-1:0] d,
                  output tone_word_t w);
    logic [LEN_W-1:0] len;
    case (fn)
      FN_TICK: begin
        if (ms_elapsed != '1) ms_elapsed = ms_elapsed + 1'b1;
      end
      FN_BEEP: begin
        on_time    = d[31:0];
        wait_time  = d[63:32];
        run_mode   = MODE_DELAY;
        ms_elapsed = '0;
      end
      FN_MELODY: begin
        len = d[70:64];
        if (len > MAX_NOTES) len = LEN_W'(MAX_NOTES);
        tune_len   = len;
        tune_pos   = '0;
        note_slot  = '0;
        ms_elapsed = '0;
        pin_level  = 1'b0;
        run_mode   = MODE_MELODY;
      end
      FN_STOP: begin
        run_mode  = MODE_IDLE;
        pin_level = 1'b0;
      end
      FN_LOAD: begin
        if (int'(d[76:71]) < MAX_NOTES) begin
          tbl_freq[d[76:71]] = d[92:77];
          tbl_type[d[76:71]] = d[107:93];
        end
      end
      default: ;
    endcase
    settle_sequencer();
    w.mode = run_mode;
    w.pin  = pin_level;
    w.pos  = tune_pos;
    if (run_mode == MODE_MELODY && note_slot != '0 && ms_elapsed < note_sound &&
        tune_pos < MAX_NOTES) begin
      w.tone = 1'b1;
      w.freq = tbl_freq[tune_pos[NOTE_AW-1:0]];
    end else begin
      w.tone = 1'b0;
      w.freq = '0;
    end
  endtask

  // Field compare; printing is capped, counting is not
  task check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 40)
        $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
    end
  endtask

  // Compare first, then take the new input word
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_sequencer();
      expected_words.delete();
      pend_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          err_count++;
          if (err_count <= 40)
            $display("%0t ns: result word 0x%0h with nothing expected, expected none actual 0x%0h",
                     $time, out_tdata, out_tdata);
        end else begin
          oldest = expected_words.pop_front();
          check_field("mode", 32'(oldest.mode), 32'(out_tdata[1:0]));
          check_field("pin_high", 32'(oldest.pin), 32'(out_tdata[2]));
          check_field("tone_on", 32'(oldest.tone), 32'(out_tdata[3]));
          check_field("tone_freq", 32'(oldest.freq), 32'(out_tdata[19:4]));
          check_field("melody_position", 32'(oldest.pos), 32'(out_tdata[26:20]));
          check_field("pad", 32'd0, 32'(out_tdata[31:27]));
          done_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        apply_word(in_tuser, in_tdata, oldest);
        expected_words.push_back(oldest);
      end
      pend_count = expected_words.size();
    end
  end

endmodule

// ===== verif/tb_beep_and_melody_sequencer.sv =====
`timescale 1ns / 1ps

module tb_beep_and_melody_sequencer;
  import bms_pkg::*;

  localparam int TOTAL_WORDS    = 1850;
  localparam int CALM_WORDS     = 150;
  localparam int HOLD_AT        = 600;
  localparam int DRAIN_AT       = 1200;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 100;
  localparam int CYCLE_LIMIT    = 8000000;
  localparam int FN_SPARE_FIRST = 5;
  localparam int FN_SPARE_LAST  = 7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int errors;
  int pending;
  int words_checked;
  int notes_started;
  int beeps_sounded;

  int   words_sent = 0;
  int   cycles = 0;
  logic calm = 1'b0;
  logic long_hold = 1'b0;
  logic [MAX_NOTES-1:0] loaded = '0;
  int   loaded_prefix = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beep_and_melody_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bms_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .notes_started (notes_started),
    .beeps_sounded (beeps_sounded)
  );

  // Input word: beep, delay, length, index, freq, type from bit 0 up
  function automatic logic [IN_TDATA_W-1:0] word_of(
    input logic [MS_W-1:0] beep_v, input logic [MS_W-1:0] delay_v,
    input logic [LEN_W-1:0] len_v, input logic [IDX_W-1:0] idx_v,
    input logic [FREQ_W-1:0] freq_v, input logic [TYPE_W-1:0] kind_v);
    return {4'b0, kind_v, freq_v, idx_v, len_v, delay_v, beep_v};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] noise_word();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    r[127:108] = '0;
    return r[IN_TDATA_W-1:0];
  endfunction

  // Spare function codes that the block ignores
  function automatic logic [FUNC_W-1:0] FunctionSpare(input int code);
    return FUNC_W'(code);
  endfunction

  // Offer one word, with an optional idle burst in front
  task send_word(input logic [FUNC_W-1:0] fn, input logic [IN_TDATA_W-1:0] d);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= noise_word();
      in_tuser  <= FUNC_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (fn == FN_LOAD) begin
      loaded[d[76:71]] = 1'b1;
      while (loaded_prefix < MAX_NOTES && loaded[NOTE_AW'(loaded_prefix)]) loaded_prefix++;
    end
  endtask

  // Stop offering until every predicted word has come back
  task wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random ready bursts, one long hold on request
  initial begin
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin : stim
    int                    pick;
    int                    ticks;
    int                    burst;
    int                    span;
    logic                  hold_done;
    logic                  drain_done;
    logic [IN_TDATA_W-1:0] d;

    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: beep corners
    send_word(FN_TICK, '0);
    send_word(FN_BEEP, word_of(2, 0, 0, 0, 0, 0));     // no delay, sounds at once
    send_word(FN_TICK, '0);
    send_word(FN_TICK, '0);                            // beep ends
    send_word(FN_BEEP, word_of(0, 0, 0, 0, 0, 0));     // zero beep idles at once
    send_word(FN_BEEP, word_of(4, 0, 0, 0, 0, 0));
    send_word(FN_BEEP, word_of(1, 2, 0, 0, 0, 0));     // restart keeps pin high
    send_word(FN_TICK, '0);
    send_word(FN_TICK, '0);
    send_word(FN_TICK, '0);
    send_word(FN_BEEP, word_of('1, '1, '0, '0, '0, '0));
    send_word(FN_STOP, '0);
    send_word(FN_BEEP, word_of('1, 0, 0, 0, 0, 0));
    send_word(FN_STOP, noise_word());

    // Directed: note table and melodies
    send_word(FN_LOAD, word_of(0, 0, 0, 0, 16'hFFFF, 15'd500));
    send_word(FN_LOAD, word_of(0, 0, 0, 1, 16'h0000, 15'h7FFF));   // zero slot
    send_word(FN_LOAD, word_of(0, 0, 0, 2, 16'h1234, 15'd0));      // type zero as one
    send_word(FN_LOAD, word_of(0, 0, 0, 3, 16'h4321, 15'd1000));
    send_word(FN_MELODY, word_of(0, 0, 0, 0, 0, 0));   // empty melody
    send_word(FN_MELODY, word_of(0, 0, 2, 0, 0, 0));
    send_word(FN_TICK, '0);
    send_word(FN_TICK, '0);                            // skips zero slot, ends
    send_word(FN_MELODY, word_of(0, 0, 4, 0, 0, 0));
    repeat (3) send_word(FN_TICK, '0);
    send_word(FN_STOP, '0);                            // stop keeps position
    send_word(FunctionSpare(FN_SPARE_FIRST), noise_word());
    send_word(FunctionSpare(FN_SPARE_LAST), noise_word());

    // Random episodes: a burst of note loads, or a command and/or a run of ticks
    while (words_sent < TOTAL_WORDS) begin
      if (!hold_done && words_sent >= HOLD_AT) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && words_sent >= DRAIN_AT) begin
        wait_drained();
        drain_done = 1'b1;
      end
      if (words_sent >= TOTAL_WORDS - CALM_WORDS) calm = 1'b1;

      pick  = $urandom_range(0, 99);
      ticks = 0;
      if (pick < 35) begin
        // burst of note loads, growing the loaded prefix first
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          d = noise_word();
          if (loaded_prefix < MAX_NOTES && $urandom_range(0, 3) != 0)
            d[76:71] = IDX_W'(loaded_prefix);
          span = $urandom_range(0, 99);
          if (span < 60)      d[107:93] = TYPE_W'($urandom_range(40, 1000));
          else if (span < 75) d[107:93] = TYPE_W'($urandom_range(1001, 32767));
          else if (span < 80) d[107:93] = TYPE_W'($urandom_range(0, 1));
          send_word(FN_LOAD, d);
        end
      end else if (pick < 55) begin
        d = noise_word();
        d[31:0]  = $urandom_range(0, 15);
        d[63:32] = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0) d[31:0] = $urandom;
        if ($urandom_range(0, 9) == 0) d[63:32] = $urandom;
        send_word(FN_BEEP, d);
        ticks = $urandom_range(0, 40);
      end else if (pick < 80) begin
        // melody only over notes already loaded
        d = noise_word();
        if (loaded_prefix >= MAX_NOTES) begin
          if ($urandom_range(0, 3) == 0) d[70:64] = LEN_W'($urandom_range(0, 127));
          else d[70:64] = LEN_W'($urandom_range(0, 6));
        end else begin
          span = (loaded_prefix < 6) ? loaded_prefix : 6;
          d[70:64] = LEN_W'($urandom_range(0, span));
        end
        send_word(FN_MELODY, d);
        ticks = $urandom_range(0, 40);
      end else if (pick < 88) begin
        send_word(FN_STOP, noise_word());
        ticks = $urandom_range(0, 3);
      end else if (pick < 92) begin
        send_word(FunctionSpare($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), noise_word());
        ticks = $urandom_range(0, 3);
      end else begin
        ticks = $urandom_range(1, 40);
      end
      repeat (ticks) send_word(FN_TICK, noise_word());
    end

    // Drain, let the block settle, then the verdict
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d result words from %0d input words in %0d cycles.",
             words_checked, words_sent, cycles);
    $display("Melody notes started: %0d, beeps sounded: %0d, notes loaded: %0d of %0d.",
             notes_started, beeps_sounded, loaded_prefix, MAX_NOTES);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bms_pkg.sv
design/bms_div.sv
design/beep_and_melody_sequencer.sv
verif/bms_checker.sv
verif/tb_beep_and_melody_sequencer.sv
